// ===== hw/rtl/dssm_pkg.sv =====
// Package for the dual stack shared memory unit.
// Field widths, operation and status codes, controller state and the
// command/status structs that join controller and datapath. No dependencies.
`default_nettype none

package dssm_pkg;

    localparam int FUNC_W = 2;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [VAL_W-1:0] TOP_EMPTY = 32'hFFFF_FFFF;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_ONE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_TWO = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP_ONE  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_POP_TWO  = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_LOAD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/dssm_if.sv =====
// Channel interfaces: request, response and configuration write.
// Depends on dssm_pkg for field widths.
`default_nettype none

interface dssm_req_if;
    import dssm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [VAL_W-1:0]  push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface dssm_rsp_if;
    import dssm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic signed [VAL_W-1:0]  top_one;
    logic signed [VAL_W-1:0]  top_two;
    logic                     empty_one;
    logic                     empty_two;

    modport source (output valid, output status, output top_one, output top_two,
                    output empty_one, output empty_two, input ready);
    modport sink   (input valid, input status, input top_one, input top_two,
                    input empty_one, input empty_two, output ready);
endinterface

interface dssm_cfg_if;
    import dssm_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dssm_ctrl.sv =====
// Controller state machine: accept, execute, read tops, load result.
// Depends on dssm_pkg.
`default_nettype none

module dssm_ctrl
    import dssm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                // wait for the output register to free up
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dssm_datapath.sv =====
// Datapath: capacity register, stack counts, shared memory, top read
// registers and the output register. Depends on dssm_pkg and dssm_if.
`default_nettype none

module dssm_datapath
    import dssm_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cmd   i_cmd,
    output t_sts        o_sts,
    dssm_req_if.sink    i_req,
    dssm_cfg_if.sink    i_cfg,
    dssm_rsp_if.source  o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CAP_W-1:0] CAP_MAX =
        (DEPTH > (2**CAP_W - 1)) ? CAP_W'(2**CAP_W - 1) : CAP_W'(DEPTH);

    logic [CAP_W-1:0]             r_capacity;
    logic [CAP_W-1:0]             r_count_one;
    logic [CAP_W-1:0]             r_count_two;
    logic [CAP_W-1:0]             n_count_one;
    logic [CAP_W-1:0]             n_count_two;
    logic [FUNC_W-1:0]            r_func;
    logic [DATA_WIDTH-1:0]        r_value;
    logic [ST_W-1:0]              r_status;
    logic [ST_W-1:0]              n_status;
    logic signed [DATA_WIDTH-1:0] r_rd_one;
    logic signed [DATA_WIDTH-1:0] r_rd_two;
    logic [DATA_WIDTH-1:0]        mem [DEPTH];

    logic                         r_out_valid;
    logic [ST_W-1:0]              r_out_status;
    logic signed [VAL_W-1:0]      r_out_top_one;
    logic signed [VAL_W-1:0]      r_out_top_two;
    logic                         r_out_empty_one;
    logic                         r_out_empty_two;

    logic [CAP_W-1:0] cap_eff;
    logic             full;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    raddr_one;
    logic [AW-1:0]    raddr_two;

    assign cap_eff = (r_capacity > CAP_MAX) ? CAP_MAX : r_capacity;
    assign full    = ({1'b0, r_count_one} + {1'b0, r_count_two}) >= {1'b0, cap_eff};

    // stack two grows down from cap_eff - 1
    always_comb begin
        n_count_one = r_count_one;
        n_count_two = r_count_two;
        n_status    = ST_OK;
        mem_we      = 1'b0;
        mem_waddr   = AW'(r_count_one);
        unique case (r_func)
            FN_PUSH_ONE: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    mem_we      = 1'b1;
                    n_count_one = r_count_one + CAP_W'(1);
                end
            end
            FN_PUSH_TWO: begin
                mem_waddr = AW'(CAP_W'(cap_eff - r_count_two - CAP_W'(1)));
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    mem_we      = 1'b1;
                    n_count_two = r_count_two + CAP_W'(1);
                end
            end
            FN_POP_ONE: begin
                if (r_count_one == '0) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_count_one = r_count_one - CAP_W'(1);
                end
            end
            FN_POP_TWO: begin
                if (r_count_two == '0) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_count_two = r_count_two - CAP_W'(1);
                end
            end
        endcase
    end

    // addresses of an empty stack are don't-care, result is masked below
    assign raddr_one = AW'(CAP_W'(r_count_one - CAP_W'(1)));
    assign raddr_two = AW'(CAP_W'(cap_eff - r_count_two));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_count_one <= '0;
            r_count_two <= '0;
        end else if (i_cfg.valid) begin
            r_capacity  <= i_cfg.capacity;
            r_count_one <= '0;
            r_count_two <= '0;
        end else if (i_cmd.exec) begin
            r_count_one <= n_count_one;
            r_count_two <= n_count_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_req.func;
            r_value <= DATA_WIDTH'(i_req.push_value);
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            mem[mem_waddr] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_one <= mem[raddr_one];
            r_rd_two <= mem[raddr_two];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status    <= r_status;
            r_out_top_one   <= (r_count_one == '0) ? TOP_EMPTY : VAL_W'(r_rd_one);
            r_out_top_two   <= (r_count_two == '0) ? TOP_EMPTY : VAL_W'(r_rd_two);
            r_out_empty_one <= (r_count_one == '0);
            r_out_empty_two <= (r_count_two == '0);
        end
    end

    assign o_sts.out_free  = !r_out_valid || o_rsp.ready;
    assign i_cfg.ready     = 1'b1;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.top_one   = r_out_top_one;
    assign o_rsp.top_two   = r_out_top_two;
    assign o_rsp.empty_one = r_out_empty_one;
    assign o_rsp.empty_two = r_out_empty_two;

endmodule

`default_nettype wire

// ===== hw/rtl/dual_stack_shared_memory_unit.sv =====
// Two stacks in one shared memory. An accepted word passes through execute,
// read tops and load output register; load waits for the output register to
// be free. A new word is taken only once the controller is back in idle. The
// output register lets the next word enter while a result waits. Reset
// empties both stacks and sets capacity to 16; memory is not cleared.
// Depends on dssm_pkg, dssm_if, dssm_ctrl, dssm_datapath.
`default_nettype none

module dual_stack_shared_memory_unit
    import dssm_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dssm_req_if.sink    i_req,
    dssm_cfg_if.sink    i_cfg,
    dssm_rsp_if.source  o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_req_ready;

    assign i_req.ready = w_req_ready;

    dssm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dssm_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_req   (i_req),
        .i_cfg   (i_cfg),
        .o_rsp   (o_rsp)
    );

    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> w_cmd.exec)
        else $error("accepted word not executed next cycle");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> w_sts.out_free)
        else $error("result loaded over a pending one");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_req.ready, w_cmd.exec, w_cmd.read, w_cmd.load}))
        else $error("controller phases overlap");

    a_exec_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> w_cmd.read)
        else $error("execute not followed by top read");

endmodule

`default_nettype wire
